>>> hdl/mfr_pkg.sv
// Shared types and codes for the monochrome framebuffer rasterizer.
package mfr_pkg;

   // Command codes of the request channel
   typedef enum logic [2:0] {
      CMD_CLEAR   = 3'd0,
      CMD_PIXEL   = 3'd1,
      CMD_LINE    = 3'd2,
      CMD_RECT    = 3'd3,
      CMD_FRECT   = 3'd4,
      CMD_CIRCLE  = 3'd5,
      CMD_FCIRCLE = 3'd6,
      CMD_READ    = 3'd7
   } cmd_type;

   // Command sequencer states
   typedef enum logic [3:0] {
      S_IDLE, S_ISSUE, S_WAIT, S_CSTEP, S_CLEAR, S_CWAIT, S_READ, S_RDATA, S_DONE
   } seq_state_type;

   // Line / span walker states
   typedef enum logic [2:0] {
      W_IDLE, W_LSWAP, W_LORD, W_LRUN, W_SRUN
   } walk_state_type;

   // Frame memory controller states
   typedef enum logic [1:0] {
      M_CLEAR, M_IDLE, M_MODIFY
   } fb_state_type;

   typedef enum logic {
      JOB_LINE, JOB_SPAN
   } job_kind_type;

   // One drawing job: a line (x0,y0)->(x1,y1) or a vertical span of cnt pixels from (x0,y0)
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   x0;
      logic [7:0]   y0;
      logic [7:0]   x1;
      logic [7:0]   y1;
      logic [7:0]   cnt;
      logic         color;
      logic         xm;
   } job_type;

   // One pixel operation
   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic       color;
      logic       xm;
   } pix_type;

   // Sequencer to frame memory controls
   typedef struct packed {
      logic       clr_start;
      logic       rd_start;
      logic [8:0] rd_index;
   } fb_ctl_type;

   // Frame memory status
   typedef struct packed {
      logic       busy;
      logic [7:0] rdata;
   } fb_stat_type;

endpackage

>>> hdl/mfr_fb.sv
// Frame memory with per-pixel read-modify-write, clearing sweep and byte read.
module mfr_fb #(
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pix_valid,
   input  mfr_pkg::pix_type     pix,
   output logic                 pix_ready,
   input  mfr_pkg::fb_ctl_type  ctl,
   output mfr_pkg::fb_stat_type stat
);

   localparam int Pages = (SCREEN_HEIGHT + 7) / 8;
   localparam int Depth = SCREEN_WIDTH * Pages;
   localparam int AW    = $clog2(Depth);

   mfr_pkg::fb_state_type state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] waddr_ff, waddr_in;
   logic [7:0]    mask_ff, mask_in;
   logic          color_ff, color_in;
   logic          xm_ff, xm_in;
   logic [7:0]    rdata_ff;
   logic [7:0]    mem [Depth];

   logic          onscreen;
   logic [AW-1:0] pix_addr;
   logic          we, re;
   logic [AW-1:0] waddr, raddr;
   logic [7:0]    wdata;

   // Pixel address decode and clipping
   assign onscreen = (32'(pix.x) < SCREEN_WIDTH) && (32'(pix.y) < SCREEN_HEIGHT);
   assign pix_addr = AW'(32'(pix.x) + 32'(pix.y[7:3]) * SCREEN_WIDTH);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfr_pkg::M_CLEAR: begin
            if (cnt_ff == AW'(Depth - 1)) state_in = mfr_pkg::M_IDLE;
         end
         mfr_pkg::M_IDLE: begin
            if (ctl.clr_start) state_in = mfr_pkg::M_CLEAR;
            else if (pix_valid && onscreen) state_in = mfr_pkg::M_MODIFY;
         end
         mfr_pkg::M_MODIFY: state_in = mfr_pkg::M_IDLE;
         default: state_in = mfr_pkg::M_IDLE;
      endcase
   end

   // Memory port controls
   always_comb begin
      we    = 1'b0;
      re    = 1'b0;
      waddr = waddr_ff;
      raddr = pix_addr;
      wdata = 8'd0;
      case (state_ff)
         mfr_pkg::M_CLEAR: begin
            we    = 1'b1;
            waddr = cnt_ff;
         end
         mfr_pkg::M_IDLE: begin
            if (pix_valid) begin
               re = onscreen;
            end else if (ctl.rd_start) begin
               re    = 1'b1;
               raddr = AW'(ctl.rd_index);
            end
         end
         mfr_pkg::M_MODIFY: begin
            we = 1'b1;
            if (xm_ff) wdata = color_ff ? (rdata_ff ^ mask_ff) : rdata_ff;
            else       wdata = color_ff ? (rdata_ff | mask_ff) : (rdata_ff & ~mask_ff);
         end
         default: ;
      endcase
   end

   assign pix_ready  = (state_ff == mfr_pkg::M_IDLE);
   assign stat.busy  = (state_ff != mfr_pkg::M_IDLE);
   assign stat.rdata = rdata_ff;

   // Datapath next values
   always_comb begin
      cnt_in   = (state_ff == mfr_pkg::M_CLEAR) ? cnt_ff + AW'(1) : '0;
      waddr_in = waddr_ff;
      mask_in  = mask_ff;
      color_in = color_ff;
      xm_in    = xm_ff;
      if (state_ff == mfr_pkg::M_IDLE) begin
         waddr_in = pix_addr;
         mask_in  = 8'd1 << pix.y[2:0];
         color_in = pix.color;
         xm_in    = pix.xm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfr_pkg::M_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      waddr_ff <= waddr_in;
      mask_ff  <= mask_in;
      color_ff <= color_in;
      xm_ff    <= xm_in;
   end

   // Frame store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

endmodule

>>> hdl/mfr_walk.sv
// Bresenham line and vertical span walker feeding pixels to the frame memory.
module mfr_walk (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_start,
   input  mfr_pkg::job_type job,
   output logic             idle,
   output logic             pix_valid,
   output mfr_pkg::pix_type pix,
   input  logic             pix_ready
);

   mfr_pkg::walk_state_type state_ff, state_in;
   logic [7:0]        ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic [7:0]        dx_ff, dx_in, dy_ff, dy_in, cnt_ff, cnt_in;
   logic signed [9:0] err_ff, err_in;
   logic              steep_ff, steep_in, up_ff, up_in;
   logic              color_ff, color_in, xm_ff, xm_in;

   logic [7:0]        adx, ady;
   logic signed [9:0] err_t;
   logic              more;

   assign adx   = (bx_ff > ax_ff) ? bx_ff - ax_ff : ax_ff - bx_ff;
   assign ady   = (by_ff > ay_ff) ? by_ff - ay_ff : ay_ff - by_ff;
   assign err_t = err_ff - $signed({2'b00, dy_ff});
   assign more  = (state_ff == mfr_pkg::W_LRUN) ? (ax_ff < bx_ff) : (cnt_ff != 8'd0);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfr_pkg::W_IDLE: begin
            if (job_start)
               state_in = (job.kind == mfr_pkg::JOB_LINE) ? mfr_pkg::W_LSWAP : mfr_pkg::W_SRUN;
         end
         mfr_pkg::W_LSWAP: state_in = mfr_pkg::W_LORD;
         mfr_pkg::W_LORD:  state_in = mfr_pkg::W_LRUN;
         mfr_pkg::W_LRUN, mfr_pkg::W_SRUN: begin
            if (!more) state_in = mfr_pkg::W_IDLE;
         end
         default: state_in = mfr_pkg::W_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      idle      = (state_ff == mfr_pkg::W_IDLE);
      pix_valid = ((state_ff == mfr_pkg::W_LRUN) || (state_ff == mfr_pkg::W_SRUN)) && more;
      pix.x     = steep_ff ? ay_ff : ax_ff;
      pix.y     = steep_ff ? ax_ff : ay_ff;
      pix.color = color_ff;
      pix.xm    = xm_ff;
   end

   // Datapath next values
   always_comb begin
      ax_in = ax_ff; ay_in = ay_ff; bx_in = bx_ff; by_in = by_ff;
      dx_in = dx_ff; dy_in = dy_ff; cnt_in = cnt_ff; err_in = err_ff;
      steep_in = steep_ff; up_in = up_ff; color_in = color_ff; xm_in = xm_ff;
      case (state_ff)
         mfr_pkg::W_IDLE: begin
            if (job_start) begin
               ax_in    = job.x0;
               ay_in    = job.y0;
               bx_in    = job.x1;
               by_in    = job.y1;
               cnt_in   = job.cnt;
               steep_in = 1'b0;
               color_in = job.color;
               xm_in    = job.xm;
            end
         end
         // Put the major axis in ax/bx
         mfr_pkg::W_LSWAP: begin
            steep_in = ady > adx;
            if (ady > adx) begin
               ax_in = ay_ff; ay_in = ax_ff;
               bx_in = by_ff; by_in = bx_ff;
            end
         end
         // Order the ends along the major axis and set up the error term
         mfr_pkg::W_LORD: begin
            if (ax_ff > bx_ff) begin
               ax_in  = bx_ff; ay_in = by_ff;
               bx_in  = ax_ff; by_in = ay_ff;
               dx_in  = ax_ff - bx_ff;
               up_in  = by_ff < ay_ff;
               err_in = $signed({3'b000, adx[7:1]});
            end else begin
               dx_in  = bx_ff - ax_ff;
               up_in  = ay_ff < by_ff;
               err_in = $signed({3'b000, adx[7:1]});
            end
            dy_in = ady;
         end
         mfr_pkg::W_LRUN: begin
            if (more && pix_ready) begin
               ax_in = ax_ff + 8'd1;
               if (err_t < 0) begin
                  ay_in  = up_ff ? ay_ff + 8'd1 : ay_ff - 8'd1;
                  err_in = err_t + $signed({2'b00, dx_ff});
               end else begin
                  err_in = err_t;
               end
            end
         end
         mfr_pkg::W_SRUN: begin
            if (more && pix_ready) begin
               ay_in  = ay_ff + 8'd1;
               cnt_in = cnt_ff - 8'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= mfr_pkg::W_IDLE;
      else       state_ff <= state_in;
      ax_ff <= ax_in; ay_ff <= ay_in; bx_ff <= bx_in; by_ff <= by_in;
      dx_ff <= dx_in; dy_ff <= dy_in; cnt_ff <= cnt_in; err_ff <= err_in;
      steep_ff <= steep_in; up_ff <= up_in; color_ff <= color_in; xm_ff <= xm_in;
   end

endmodule

>>> hdl/monochrome_framebuffer_rasterizer_unit.sv
// Top level: command sequencer of the monochrome framebuffer rasterizer.
//
// Request channel (req_valid/req_ready) carries one command per transfer: clear,
// pixel, line, rectangle, filled rectangle, circle, filled circle or byte read.
// Response channel (rsp_valid/rsp_ready) returns exactly one item per command:
// rsp_is_read high with the stored byte for a read, zero otherwise.
// Commands run one at a time. An on-screen pixel is a read-modify-write of the
// frame memory; a clipped one does not touch it. Each line job first passes the
// swap and order states of the walker; a span starts walking at once. A read
// passes S_READ and S_RDATA before its response; a clear sweeps
// SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes (384 by default).
// The memory port is the limit: one pixel in flight at a time.
// After reset the memory is cleared by a sweep of one byte per cycle
// while req_ready stays low.
// A finished command waits in the response register; the next command is
// accepted meanwhile but cannot complete until the response is taken.
module monochrome_framebuffer_rasterizer_unit #(
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 48
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_command,
   input  logic [7:0] req_x_start,
   input  logic [7:0] req_y_start,
   input  logic [7:0] req_x_end,
   input  logic [7:0] req_y_end,
   input  logic [7:0] req_width,
   input  logic [7:0] req_height,
   input  logic [5:0] req_radius,
   input  logic       req_color,
   input  logic       req_xor_mode,
   input  logic [8:0] req_byte_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_is_read
);

   localparam int Depth = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);

   mfr_pkg::seq_state_type state_ff, state_in;
   mfr_pkg::cmd_type       cmd_ff, cmd_in;
   logic [7:0] xs_ff, xs_in, ys_ff, ys_in, xe_ff, xe_in, ye_ff, ye_in;
   logic [7:0] w_ff, w_in, h_ff, h_in, idx_ff, idx_in, rbyte_ff, rbyte_in;
   logic [8:0] bi_ff, bi_in;
   logic       color_ff, color_in, xm_ff, xm_in, init_ff, init_in;
   logic [5:0] a_ff, a_in, b_ff, b_in;
   logic signed [9:0] f_ff, f_in, ddx_ff, ddx_in, ddy_ff, ddy_in;
   logic       rsp_valid_ff, rsp_valid_in, rsp_isrd_ff, rsp_isrd_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;

   logic                 accept, job_start, job_ok, job_end, walk_idle, pix_valid, pix_ready;
   mfr_pkg::job_type     job;
   mfr_pkg::pix_type     pix;
   mfr_pkg::fb_ctl_type  fb_ctl;
   mfr_pkg::fb_stat_type fb_stat;
   logic [7:0]        a8, b8, px, py, half;
   logic signed [9:0] ddy_n, f1;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == mfr_pkg::S_IDLE) && !fb_stat.busy;
   assign a8        = {2'b00, a_ff};
   assign b8        = {2'b00, b_ff};

   // Circle point / span selection from the job index
   always_comb begin
      if (idx_ff[2]) begin
         px = idx_ff[0] ? xs_ff - b8 : xs_ff + b8;
         py = idx_ff[1] ? ys_ff - a8 : ys_ff + a8;
      end else begin
         px = idx_ff[0] ? xs_ff - a8 : xs_ff + a8;
         py = idx_ff[1] ? ys_ff - b8 : ys_ff + b8;
      end
      half = idx_ff[1] ? a8 : b8;
   end

   // Job list of the current command
   always_comb begin
      job       = '0;
      job.kind  = mfr_pkg::JOB_LINE;
      job.color = color_ff;
      job.xm    = xm_ff;
      job_ok    = 1'b0;
      job_end   = 1'b0;
      case (cmd_ff)
         mfr_pkg::CMD_PIXEL: begin
            job.kind = mfr_pkg::JOB_SPAN;
            job.x0   = xs_ff;
            job.y0   = ys_ff;
            job.cnt  = 8'd1;
            job_ok   = 1'b1;
            job_end  = idx_ff != 8'd0;
         end
         mfr_pkg::CMD_LINE: begin
            job.x0  = xs_ff; job.y0 = ys_ff; job.x1 = xe_ff; job.y1 = ye_ff;
            job_ok  = 1'b1;
            job_end = idx_ff != 8'd0;
         end
         mfr_pkg::CMD_RECT: begin
            job_ok = 1'b1;
            case (idx_ff)
               8'd0: begin
                  job.x0 = xs_ff; job.y0 = ys_ff; job.x1 = xs_ff + w_ff; job.y1 = ys_ff;
               end
               8'd1: begin
                  job.x0 = xs_ff; job.y0 = ys_ff + h_ff - 8'd1;
                  job.x1 = xs_ff + w_ff; job.y1 = ys_ff + h_ff - 8'd1;
               end
               8'd2: begin
                  // sides only for rectangles of three rows or more
                  job.x0 = xs_ff; job.y0 = ys_ff + 8'd1;
                  job.x1 = xs_ff; job.y1 = ys_ff + h_ff - 8'd1;
                  job_end = h_ff < 8'd3;
               end
               8'd3: begin
                  job.x0 = xs_ff + w_ff - 8'd1; job.y0 = ys_ff + 8'd1;
                  job.x1 = xs_ff + w_ff - 8'd1; job.y1 = ys_ff + h_ff - 8'd1;
               end
               default: job_end = 1'b1;
            endcase
         end
         mfr_pkg::CMD_FRECT: begin
            job.x0  = xs_ff + idx_ff; job.y0 = ys_ff;
            job.x1  = xs_ff + idx_ff; job.y1 = ys_ff + h_ff;
            job_ok  = 1'b1;
            job_end = idx_ff >= w_ff;
         end
         mfr_pkg::CMD_CIRCLE: begin
            job.kind = mfr_pkg::JOB_SPAN;
            job.x0   = px;
            job.y0   = py;
            job.cnt  = 8'd1;
            // first octant set plots only the four axis points
            job_ok   = !init_ff || (idx_ff[2:0] == 3'd0) || (idx_ff[2:0] == 3'd2) ||
                       (idx_ff[2:0] == 3'd4) || (idx_ff[2:0] == 3'd5);
            job_end  = idx_ff[3];
         end
         mfr_pkg::CMD_FCIRCLE: begin
            job.kind = mfr_pkg::JOB_SPAN;
            job.x0   = idx_ff[1] ? (idx_ff[0] ? xs_ff - b8 : xs_ff + b8)
                                 : (idx_ff[0] ? xs_ff - a8 : xs_ff + a8);
            job.y0   = ys_ff - half;
            job.cnt  = {half[6:0], 1'b1};
            job_ok   = !init_ff || (idx_ff == 8'd0);
            job_end  = idx_ff[2];
         end
         default: job_end = 1'b1;
      endcase
   end

   assign job_start = (state_ff == mfr_pkg::S_ISSUE) && !job_end && job_ok;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfr_pkg::S_IDLE: begin
            if (accept) begin
               case (mfr_pkg::cmd_type'(req_command))
                  mfr_pkg::CMD_CLEAR: state_in = mfr_pkg::S_CLEAR;
                  mfr_pkg::CMD_READ:  state_in = mfr_pkg::S_READ;
                  mfr_pkg::CMD_FCIRCLE:
                     state_in = req_xor_mode ? mfr_pkg::S_DONE : mfr_pkg::S_ISSUE;
                  default: state_in = mfr_pkg::S_ISSUE;
               endcase
            end
         end
         mfr_pkg::S_ISSUE: begin
            if (job_end)
               state_in = ((cmd_ff == mfr_pkg::CMD_CIRCLE) || (cmd_ff == mfr_pkg::CMD_FCIRCLE))
                          ? mfr_pkg::S_CSTEP : mfr_pkg::S_DONE;
            else if (job_ok)
               state_in = mfr_pkg::S_WAIT;
         end
         mfr_pkg::S_WAIT: begin
            if (walk_idle && !fb_stat.busy) state_in = mfr_pkg::S_ISSUE;
         end
         mfr_pkg::S_CSTEP: state_in = (a_ff < b_ff) ? mfr_pkg::S_ISSUE : mfr_pkg::S_DONE;
         mfr_pkg::S_CLEAR: state_in = mfr_pkg::S_CWAIT;
         mfr_pkg::S_CWAIT: begin
            if (!fb_stat.busy) state_in = mfr_pkg::S_DONE;
         end
         mfr_pkg::S_READ:  state_in = mfr_pkg::S_RDATA;
         mfr_pkg::S_RDATA: state_in = mfr_pkg::S_DONE;
         mfr_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = mfr_pkg::S_IDLE;
         end
         default: state_in = mfr_pkg::S_IDLE;
      endcase
   end

   // Frame memory controls
   always_comb begin
      fb_ctl.clr_start = (state_ff == mfr_pkg::S_CLEAR);
      fb_ctl.rd_start  = (state_ff == mfr_pkg::S_READ);
      fb_ctl.rd_index  = bi_ff;
   end

   // Midpoint circle step
   assign ddy_n = (f_ff >= 0) ? ddy_ff + 10'sd2 : ddy_ff;
   assign f1    = (f_ff >= 0) ? f_ff + ddy_n : f_ff;

   // Datapath next values
   always_comb begin
      cmd_in = cmd_ff; xs_in = xs_ff; ys_in = ys_ff; xe_in = xe_ff; ye_in = ye_ff;
      w_in = w_ff; h_in = h_ff; bi_in = bi_ff; color_in = color_ff; xm_in = xm_ff;
      idx_in = idx_ff; init_in = init_ff; a_in = a_ff; b_in = b_ff;
      f_in = f_ff; ddx_in = ddx_ff; ddy_in = ddy_ff; rbyte_in = rbyte_ff;
      rsp_valid_in = rsp_valid_ff; rsp_byte_in = rsp_byte_ff; rsp_isrd_in = rsp_isrd_ff;
      case (state_ff)
         mfr_pkg::S_IDLE: begin
            if (accept) begin
               cmd_in   = mfr_pkg::cmd_type'(req_command);
               xs_in    = req_x_start; ys_in = req_y_start;
               xe_in    = req_x_end;   ye_in = req_y_end;
               w_in     = req_width;   h_in  = req_height;
               bi_in    = req_byte_index;
               color_in = req_color;   xm_in = req_xor_mode;
               idx_in   = 8'd0;
               init_in  = 1'b1;
               a_in     = 6'd0;
               b_in     = req_radius;
               f_in     = 10'sd1 - $signed({4'b0000, req_radius});
               ddx_in   = 10'sd1;
               ddy_in   = 10'sd0 - $signed({3'b000, req_radius, 1'b0});
            end
         end
         mfr_pkg::S_ISSUE: begin
            if (!job_end) idx_in = idx_ff + 8'd1;
         end
         mfr_pkg::S_CSTEP: begin
            if (a_ff < b_ff) begin
               if (f_ff >= 0) b_in = b_ff - 6'd1;
               ddy_in  = ddy_n;
               a_in    = a_ff + 6'd1;
               ddx_in  = ddx_ff + 10'sd2;
               f_in    = f1 + ddx_ff + 10'sd2;
               idx_in  = 8'd0;
               init_in = 1'b0;
            end
         end
         mfr_pkg::S_RDATA: begin
            rbyte_in = (32'(bi_ff) < Depth) ? fb_stat.rdata : 8'd0;
         end
         default: ;
      endcase
      // Response register
      if ((state_ff == mfr_pkg::S_DONE) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
         rsp_isrd_in  = (cmd_ff == mfr_pkg::CMD_READ);
         rsp_byte_in  = (cmd_ff == mfr_pkg::CMD_READ) ? rbyte_ff : 8'd0;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfr_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in; xs_ff <= xs_in; ys_ff <= ys_in; xe_ff <= xe_in; ye_ff <= ye_in;
      w_ff <= w_in; h_ff <= h_in; bi_ff <= bi_in; color_ff <= color_in; xm_ff <= xm_in;
      idx_ff <= idx_in; init_ff <= init_in; a_ff <= a_in; b_ff <= b_in;
      f_ff <= f_in; ddx_ff <= ddx_in; ddy_ff <= ddy_in; rbyte_ff <= rbyte_in;
      rsp_byte_ff <= rsp_byte_in; rsp_isrd_ff <= rsp_isrd_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_byte_ff;
   assign rsp_is_read   = rsp_isrd_ff;

   mfr_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .job_start (job_start),
      .job       (job),
      .idle      (walk_idle),
      .pix_valid (pix_valid),
      .pix       (pix),
      .pix_ready (pix_ready)
   );

   mfr_fb #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_fb (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (pix_valid),
      .pix       (pix),
      .pix_ready (pix_ready),
      .ctl       (fb_ctl),
      .stat      (fb_stat)
   );

`ifndef SYNTHESIS
   // A job is only handed to an idle walker
   a_job_idle: assert property (@(posedge clock) disable iff (reset)
      job_start |-> walk_idle) else $error("job started while walker busy");

   // No command is taken while the memory is clearing or modifying
   a_busy_block: assert property (@(posedge clock) disable iff (reset)
      fb_stat.busy |-> !req_ready) else $error("request accepted while memory busy");

   // Pixels flow only while the sequencer waits on a job
   a_pix_wait: assert property (@(posedge clock) disable iff (reset)
      pix_valid |-> (state_ff == mfr_pkg::S_WAIT)) else $error("pixel outside a job");
`endif

endmodule

>>> tb/tb_monochrome_framebuffer_rasterizer_unit.sv
// Self-checking testbench for the monochrome framebuffer rasterizer top level.
module tb_monochrome_framebuffer_rasterizer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCR_W      = 64;
   localparam int SCR_H      = 48;
   localparam int FB_SIZE    = SCR_W * ((SCR_H + 7) / 8);
   localparam int RAND_ITEMS = 930;
   localparam int CYCLE_CAP  = 8000000;
   localparam int TAIL_WAIT  = 600;
   localparam int HOLD_LEN   = 3000;

   typedef struct {
      mfr_pkg::cmd_type cmd;
      logic [7:0] xs, ys, xe, ye, w, h;
      logic [5:0] r;
      logic       color, xm;
      logic [8:0] bidx;
      bit         drain;   // sender waits for all responses before offering it
   } draw_cmd_type;

   typedef struct {
      logic [7:0] rbyte;
      logic       isrd;
   } rsp_type;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [2:0] req_command = mfr_pkg::CMD_CLEAR;
   logic [7:0] req_x_start = 0, req_y_start = 0, req_x_end = 0, req_y_end = 0;
   logic [7:0] req_width = 0, req_height = 0;
   logic [5:0] req_radius = 0;
   logic       req_color = 0, req_xor_mode = 0;
   logic [8:0] req_byte_index = 0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic [7:0] rsp_read_byte;
   logic       rsp_is_read;

   draw_cmd_type pending_cmds[$];
   rsp_type      expected_rsps[$];
   draw_cmd_type held;
   logic [7:0] shadow_fb [0:FB_SIZE-1];
   int         errors = 0;
   int         accepted_count = 0;
   int         send_gap = 0;
   int         recv_gap = 0;
   int         cycles = 0;
   logic       hold_rsp = 0;

   monochrome_framebuffer_rasterizer_unit #(.SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_x_start(req_x_start), .req_y_start(req_y_start),
      .req_x_end(req_x_end), .req_y_end(req_y_end),
      .req_width(req_width), .req_height(req_height), .req_radius(req_radius),
      .req_color(req_color), .req_xor_mode(req_xor_mode), .req_byte_index(req_byte_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_read_byte(rsp_read_byte), .rsp_is_read(rsp_is_read)
   );

   always #10 clock = ~clock;

   // ---------------- shadow framebuffer ----------------
   function automatic void plot(int x, int y, logic c, logic xm);
      int idx;
      logic [7:0] mask;
      x = x & 255;
      y = y & 255;
      if (x >= SCR_W || y >= SCR_H) return;
      idx  = x + (y >> 3) * SCR_W;
      mask = 8'd1 << (y & 7);
      if (xm) begin
         if (c) shadow_fb[idx] ^= mask;
      end else if (c) begin
         shadow_fb[idx] |= mask;
      end else begin
         shadow_fb[idx] &= ~mask;
      end
   endfunction

   function automatic void bresenham(int ax, int ay, int bx, int by, logic c, logic xm);
      int adx, ady, dx, dy, err, t, ystep, x;
      bit steep;
      ax &= 255; ay &= 255; bx &= 255; by &= 255;
      adx = (bx > ax) ? bx - ax : ax - bx;
      ady = (by > ay) ? by - ay : ay - by;
      steep = ady > adx;
      if (steep) begin
         t = ax; ax = ay; ay = t;
         t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
         t = ax; ax = bx; bx = t;
         t = ay; ay = by; by = t;
      end
      dx    = bx - ax;
      dy    = (by > ay) ? by - ay : ay - by;
      err   = dx / 2;
      ystep = (ay < by) ? 1 : 255;
      for (x = ax; x < bx; x++) begin
         if (steep) plot(ay, x, c, xm);
         else plot(x, ay, c, xm);
         err -= dy;
         if (err < 0) begin
            ay = (ay + ystep) & 255;
            err += dx;
         end
      end
   endfunction

   function automatic void column_span(int x, int yc, int half, logic c);
      int y0;
      y0 = (yc - half) & 255;
      for (int k = 0; k < 2 * half + 1; k++) plot(x, y0 + k, c, 1'b0);
   endfunction

   function automatic void midpoint_circle(int cx, int cy, int r, bit fill, logic c, logic xm);
      int f, ddx, ddy, x, y;
      f = 1 - r; ddx = 1; ddy = -2 * r; x = 0; y = r;
      if (fill) begin
         if (xm) return;
         column_span(cx, cy, r, c);
      end else begin
         plot(cx, cy + r, c, xm);
         plot(cx, cy - r, c, xm);
         plot(cx + r, cy, c, xm);
         plot(cx - r, cy, c, xm);
      end
      while (x < y) begin
         if (f >= 0) begin
            y--;
            ddy += 2;
            f += ddy;
         end
         x++;
         ddx += 2;
         f += ddx;
         if (fill) begin
            column_span(cx + x, cy, y, c);
            column_span(cx - x, cy, y, c);
            column_span(cx + y, cy, x, c);
            column_span(cx - y, cy, x, c);
         end else begin
            plot(cx + x, cy + y, c, xm); plot(cx - x, cy + y, c, xm);
            plot(cx + x, cy - y, c, xm); plot(cx - x, cy - y, c, xm);
            plot(cx + y, cy + x, c, xm); plot(cx - y, cy + x, c, xm);
            plot(cx + y, cy - x, c, xm); plot(cx - y, cy - x, c, xm);
         end
      end
   endfunction

   // Apply one accepted command to the shadow buffer and queue its response
   function automatic void rasterize_cmd(draw_cmd_type d);
      rsp_type e;
      int x, y, w, h;
      x = d.xs; y = d.ys; w = d.w; h = d.h;
      e.rbyte = 8'd0;
      e.isrd  = 1'b0;
      case (d.cmd)
         mfr_pkg::CMD_CLEAR:   for (int i = 0; i < FB_SIZE; i++) shadow_fb[i] = 8'd0;
         mfr_pkg::CMD_PIXEL:   plot(x, y, d.color, d.xm);
         mfr_pkg::CMD_LINE:    bresenham(x, y, d.xe, d.ye, d.color, d.xm);
         mfr_pkg::CMD_RECT: begin
            bresenham(x, y, x + w, y, d.color, d.xm);
            bresenham(x, y + h - 1, x + w, y + h - 1, d.color, d.xm);
            // short rectangles have no side lines
            if (h >= 3) begin
               bresenham(x, y + 1, x, y + h - 1, d.color, d.xm);
               bresenham(x + w - 1, y + 1, x + w - 1, y + h - 1, d.color, d.xm);
            end
         end
         mfr_pkg::CMD_FRECT:   for (int i = 0; i < w; i++)
                                  bresenham(x + i, y, x + i, y + h, d.color, d.xm);
         mfr_pkg::CMD_CIRCLE:  midpoint_circle(x, y, d.r, 1'b0, d.color, d.xm);
         mfr_pkg::CMD_FCIRCLE: midpoint_circle(x, y, d.r, 1'b1, d.color, d.xm);
         default: begin
            e.rbyte = (d.bidx < FB_SIZE) ? shadow_fb[d.bidx] : 8'd0;
            e.isrd  = 1'b1;
         end
      endcase
      expected_rsps.push_back(e);
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 120);
   endfunction

   function automatic logic [7:0] near_coord();
      if ($urandom_range(0, 9) < 8) return 8'($urandom_range(0, 72));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] fill_size();
      if ($urandom_range(0, 19) < 18) return 8'($urandom_range(0, 14));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic draw_cmd_type mk(mfr_pkg::cmd_type c, int xs, int ys, int xe, int ye,
                                       int w, int h, int r, bit color, bit xm, int bidx);
      draw_cmd_type d;
      d.cmd = c; d.xs = 8'(xs); d.ys = 8'(ys); d.xe = 8'(xe); d.ye = 8'(ye);
      d.w = 8'(w); d.h = 8'(h);
      d.r = 6'(r); d.color = color; d.xm = xm; d.bidx = 9'(bidx); d.drain = 0;
      return d;
   endfunction

   function automatic draw_cmd_type random_cmd();
      draw_cmd_type d;
      int p;
      d = mk(mfr_pkg::CMD_READ, $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 63),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom_range(0, 511));
      p = $urandom_range(0, 99);
      if (p < 36) begin
         d.cmd = mfr_pkg::CMD_READ;
         if ($urandom_range(0, 9) < 9) d.bidx = 9'($urandom_range(0, FB_SIZE - 1));
      end else begin
         d.xs = near_coord();
         d.ys = near_coord();
         d.xe = near_coord();
         d.ye = near_coord();
         if (p < 50) d.cmd = mfr_pkg::CMD_PIXEL;
         else if (p < 65) d.cmd = mfr_pkg::CMD_LINE;
         else if (p < 75) begin
            d.cmd = mfr_pkg::CMD_RECT;
            d.w = near_coord();
            d.h = near_coord();
         end else if (p < 83) begin
            d.cmd = mfr_pkg::CMD_FRECT;
            d.w = fill_size();
            d.h = fill_size();
            // keep one side short when the other is large
            if (d.w > 20 && d.h > 20) d.h = 8'($urandom_range(0, 8));
         end else if (p < 92) d.cmd = mfr_pkg::CMD_CIRCLE;
         else if (p < 99) begin
            d.cmd = mfr_pkg::CMD_FCIRCLE;
            if ($urandom_range(0, 9) < 9) d.r = 6'($urandom_range(0, 15));
         end else d.cmd = mfr_pkg::CMD_CLEAR;
      end
      return d;
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      bit fire;
      fire = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            rasterize_cmd(held);
            accepted_count++;
            send_gap = pick_gap();
         end
         if (req_valid && !fire) begin
            // hold the offered transfer
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() > 0 &&
                      !(pending_cmds[0].drain && expected_rsps.size() != 0)) begin
            held = pending_cmds.pop_front();
            req_valid      <= 1'b1;
            req_command    <= held.cmd;
            req_x_start    <= held.xs;
            req_y_start    <= held.ys;
            req_x_end      <= held.xe;
            req_y_end      <= held.ye;
            req_width      <= held.w;
            req_height     <= held.h;
            req_radius     <= held.r;
            req_color      <= held.color;
            req_xor_mode   <= held.xm;
            req_byte_index <= held.bidx;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------
   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response, is_read", rsp_is_read, -1);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_is_read !== e.isrd) report_mismatch("is_read", rsp_is_read, e.isrd);
               if (rsp_read_byte !== e.rbyte)
                  report_mismatch("read_byte", rsp_read_byte, e.rbyte);
            end
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            recv_gap = pick_gap();
            rsp_ready <= (recv_gap == 0);
         end
      end
   end

   // Long receiver hold-off so the block backs up and stalls its input
   initial begin
      wait (accepted_count >= 300);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------- sequence ----------------
   initial begin
      draw_cmd_type d;
      // directed part: field extremes, clipping, wrap and short-shape cases
      pending_cmds.push_back(mk(mfr_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_PIXEL, 63, 47, 255, 255, 255, 255, 63, 1, 0, 511));
      pending_cmds.push_back(mk(mfr_pkg::CMD_PIXEL, 64, 48, 0, 0, 0, 0, 0, 1, 0, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_PIXEL, 255, 255, 0, 0, 0, 0, 0, 1, 1, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_PIXEL, 63, 47, 0, 0, 0, 0, 0, 1, 1, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 383));
      pending_cmds.push_back(mk(mfr_pkg::CMD_LINE, 5, 5, 5, 5, 0, 0, 0, 1, 0, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_LINE, 60, 2, 3, 40, 0, 0, 0, 1, 0, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_LINE, 10, 45, 12, 1, 0, 0, 0, 1, 1, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_LINE, 250, 250, 20, 30, 0, 0, 0, 1, 0, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_RECT, 2, 3, 0, 0, 10, 1, 0, 1, 0, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_RECT, 20, 10, 0, 0, 8, 2, 0, 1, 1, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_RECT, 30, 20, 0, 0, 0, 3, 0, 1, 0, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_RECT, 250, 250, 0, 0, 40, 0, 0, 1, 0, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_FRECT, 40, 30, 0, 0, 12, 9, 0, 1, 1, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_CIRCLE, 32, 24, 0, 0, 0, 0, 0, 1, 0, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_CIRCLE, 32, 24, 0, 0, 0, 0, 63, 1, 1, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_FCIRCLE, 20, 20, 0, 0, 0, 0, 9, 1, 1, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_FCIRCLE, 2, 2, 0, 0, 0, 0, 63, 0, 0, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 384));
      pending_cmds.push_back(mk(mfr_pkg::CMD_FRECT, 0, 0, 0, 0, 255, 255, 0, 1, 0, 0));
      pending_cmds.push_back(mk(mfr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 200));
      pending_cmds.push_back(mk(mfr_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // random part, with a few points where the sender drains the block
      for (int i = 0; i < RAND_ITEMS; i++) begin
         d = random_cmd();
         if (i == 500 || $urandom_range(0, 199) == 0) d.drain = 1;
         pending_cmds.push_back(d);
      end
      for (int i = 0; i < FB_SIZE; i++) shadow_fb[i] = 8'd0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
